@@ hw/rtl/bxd_pkg.sv @@
`default_nettype none
package bxd_pkg;

    localparam int MAX_OUT_EDGE = 4096;
    localparam int MAX_IN_EDGE  = 16384;

    localparam int IN_W    = 15;   // input frame dimension registers
    localparam int EDGE_W  = 13;   // target edge register
    localparam int POS_W   = 14;   // input column and row positions
    localparam int OPOS_W  = 12;   // output column and row positions
    localparam int OSZ_W   = 13;   // output frame dimensions
    localparam int SUM_W   = 36;   // per-channel column sum
    localparam int CNT_W   = 29;   // pixel count of one box
    localparam int MUL_W   = 15;   // multiplier operand
    localparam int PROD_W  = 2 * MUL_W;
    localparam int NUM_W   = 38;   // divider dividend and quotient
    localparam int DEN_W   = 30;   // divider divisor
    localparam int DCNT_W  = 6;
    localparam int ADDR_W  = $clog2(MAX_OUT_EDGE);
    localparam int PADDR_W = 4;

    localparam logic [1:0] REG_IN_WIDTH    = 2'd0;
    localparam logic [1:0] REG_IN_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_OUT_EDGE    = 2'd2;

    function automatic logic [IN_W-1:0] clamp_in(input logic [IN_W-1:0] v);
        logic [IN_W-1:0] r;
        r = v;
        if (v == '0) r = IN_W'(1);
        else if (v > IN_W'(MAX_IN_EDGE)) r = IN_W'(MAX_IN_EDGE);
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/box_average_image_downscaler_top.sv @@
`default_nettype none
// Area-average downscaler for RGB pixels in raster order. The output frame keeps the
// aspect ratio with its longer edge cut to the configured edge length; each output word
// is the rounded mean of its input box and comes out with the pixel that closes that box.
// One pixel is worked on at a time through a single bit-serial divider (six divisions per
// pixel, a seventh when the pixel moves into the next output column): the input is held
// off from the accepted pixel until its work is done, so a new pixel is not taken before
// the last is through. A pixel that completes an output word adds the box count and three
// more divisions for the channel means, and waits while a pending output is stalled. Column
// sums live in one synchronous RAM of 4096 entries, read and written back per pixel.
// Write the size registers only between frames.
module box_average_image_downscaler_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bxd_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [7:0]                        i_pix_red,
    input  wire logic [7:0]                        i_pix_green,
    input  wire logic [7:0]                        i_pix_blue,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic      [7:0]                        o_avg_red,
    output logic      [7:0]                        o_avg_green,
    output logic      [7:0]                        o_avg_blue,
    output logic      [11:0]                       o_out_col,
    output logic      [11:0]                       o_out_line,
    output logic                                   o_frame_done
);
    import bxd_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE = 19'b0000000000000000001,
        S_SZW  = 19'b0000000000000000010,
        S_SZH  = 19'b0000000000000000100,
        S_CHK  = 19'b0000000000000001000,
        S_CE0  = 19'b0000000000000010000,
        S_CE1  = 19'b0000000000000100000,
        S_CER  = 19'b0000000000001000000,
        S_CS   = 19'b0000000000010000000,
        S_RS   = 19'b0000000000100000000,
        S_RE   = 19'b0000000001000000000,
        S_MEM  = 19'b0000000010000000000,
        S_ACC  = 19'b0000000100000000000,
        S_CNT  = 19'b0000001000000000000,
        S_MR   = 19'b0000010000000000000,
        S_MG   = 19'b0000100000000000000,
        S_MB   = 19'b0001000000000000000,
        S_OUT  = 19'b0010000000000000000,
        S_UPD  = 19'b0100000000000000000,
        S_DIV  = 19'b1000000000000000000
    } t_state;

    t_state r_state, r_ret;

    logic [IN_W-1:0]   r_in_width, r_in_height;
    logic [EDGE_W-1:0] r_edge_len;

    logic [7:0] r_pr, r_pg, r_pb;
    logic [POS_W-1:0]  r_icp, r_irp;
    logic [OPOS_W-1:0] r_ocp, r_orp;
    logic [OSZ_W-1:0]  r_w, r_h;
    logic [IN_W-1:0]   r_ce, r_cs, r_rs, r_re;
    logic [CNT_W-1:0]  r_count;
    logic [SUM_W-1:0]  r_sr, r_sg, r_sb;
    logic [7:0]        r_ar, r_ag;
    logic              r_emit;

    logic [NUM_W-1:0]  r_q;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    r_rem;
    logic [DCNT_W-1:0] r_dcnt;

    logic [3*SUM_W-1:0] r_mem [MAX_OUT_EDGE];
    logic [3*SUM_W-1:0] r_rdata;

    logic r_ovalid;

    // Configuration derived values.
    logic [IN_W-1:0]   cw, ch, cl;
    logic [EDGE_W-1:0] ce_edge;
    always_comb begin
        cw = clamp_in(r_in_width);
        ch = clamp_in(r_in_height);
        cl = (cw > ch) ? cw : ch;
        ce_edge = (r_edge_len > EDGE_W'(MAX_OUT_EDGE)) ? EDGE_W'(MAX_OUT_EDGE)
                                                       : r_edge_len;
    end

    // Shared multiplier; its product always lands in a register.
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    logic [DEN_W-1:0]  den_sel;
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        den_sel = {{(DEN_W-OSZ_W){1'b0}}, r_w};
        case (r_state)
            S_SZW: begin
                mul_a = cw; mul_b = MUL_W'(ce_edge); den_sel = DEN_W'(cl);
            end
            S_SZH: begin
                mul_a = ch; mul_b = MUL_W'(ce_edge); den_sel = DEN_W'(cl);
            end
            S_CE0: begin
                mul_a = MUL_W'(r_ocp) + MUL_W'(1); mul_b = cw;
            end
            S_CE1: begin
                mul_a = MUL_W'(r_ocp) + MUL_W'(2); mul_b = cw;
            end
            S_CS: begin
                mul_a = MUL_W'(r_ocp); mul_b = cw;
            end
            S_RS: begin
                mul_a = MUL_W'(r_orp); mul_b = ch; den_sel = DEN_W'(r_h);
            end
            S_RE: begin
                mul_a = MUL_W'(r_orp) + MUL_W'(1); mul_b = ch; den_sel = DEN_W'(r_h);
            end
            S_CNT: begin
                mul_a = r_ce - r_cs; mul_b = r_re - r_rs;
            end
            default: begin
                mul_a = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    // Divider step.
    logic [DEN_W:0] trial;
    logic           take;
    always_comb begin
        trial = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
        take  = trial >= {1'b0, r_den};
    end

    logic [OSZ_W-1:0] q_size;
    always_comb begin
        q_size = (r_q[OSZ_W-1:0] == '0) ? OSZ_W'(1) : r_q[OSZ_W-1:0];
    end

    // Accumulation of the arriving pixel into its column sum.
    logic              band_first;
    logic [SUM_W-1:0]  acc_r, acc_g, acc_b;
    always_comb begin
        band_first = {1'b0, r_irp} == r_rs;
        acc_r = band_first ? SUM_W'(r_pr) : r_rdata[3*SUM_W-1:2*SUM_W] + SUM_W'(r_pr);
        acc_g = band_first ? SUM_W'(r_pg) : r_rdata[2*SUM_W-1:SUM_W] + SUM_W'(r_pg);
        acc_b = band_first ? SUM_W'(r_pb) : r_rdata[SUM_W-1:0] + SUM_W'(r_pb);
    end

    logic [IN_W-1:0] n_icp, n_irp;
    always_comb begin
        n_icp = IN_W'(r_icp) + IN_W'(1);
        n_irp = IN_W'(r_irp) + IN_W'(1);
    end

    logic out_free;
    assign out_free = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_icp   <= '0;
            r_irp   <= '0;
            r_ocp   <= '0;
            r_orp   <= '0;
            r_dcnt  <= '0;
            r_ovalid <= 1'b0;
            r_in_width    <= IN_W'(1024);
            r_in_height   <= IN_W'(1024);
            r_edge_len    <= EDGE_W'(256);
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    REG_IN_WIDTH:    r_in_width    <= pwdata[IN_W-1:0];
                    REG_IN_HEIGHT:   r_in_height   <= pwdata[IN_W-1:0];
                    REG_OUT_EDGE:    r_edge_len    <= pwdata[EDGE_W-1:0];
                    default: ;
                endcase
            end
            // In S_OUT the output handshake is handled by the state itself.
            if (r_ovalid && !i_stall && r_state != S_OUT) r_ovalid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (i_valid) r_state <= S_SZW;
                end
                S_SZW: begin
                    r_ret <= S_SZH; r_state <= S_DIV;
                end
                S_SZH: begin
                    r_w <= (ce_edge >= cl) ? OSZ_W'(cw) : q_size;
                    r_ret <= S_CHK; r_state <= S_DIV;
                end
                S_CHK: begin
                    r_h <= (ce_edge >= cl) ? OSZ_W'(ch) : q_size;
                    if ({1'b0, r_icp} >= cw || {1'b0, r_irp} >= ch
                        || {1'b0, r_ocp} >= r_w) begin
                        r_icp <= '0; r_irp <= '0; r_ocp <= '0; r_orp <= '0;
                    end else if (r_icp == '0) begin
                        r_ocp <= '0;
                    end
                    // The row check needs the new output height, so it is made in S_CE0.
                    r_state <= S_CE0;
                end
                S_CE0: begin
                    if ({1'b0, r_orp} >= r_h) begin
                        r_icp <= '0; r_irp <= '0; r_ocp <= '0; r_orp <= '0;
                        r_state <= S_CE0;
                    end else begin
                        r_ret <= S_CE1; r_state <= S_DIV;
                    end
                end
                S_CE1: begin
                    r_ce <= r_q[IN_W-1:0];
                    if ({1'b0, r_icp} >= r_q[IN_W-1:0]
                        && OSZ_W'(r_ocp) + OSZ_W'(1) < r_w) begin
                        r_ocp <= r_ocp + OPOS_W'(1);
                        r_ret <= S_CER; r_state <= S_DIV;
                    end else begin
                        r_state <= S_CS;
                    end
                end
                S_CER: begin
                    r_ce <= r_q[IN_W-1:0];
                    r_state <= S_CS;
                end
                S_CS: begin
                    r_ret <= S_RS; r_state <= S_DIV;
                end
                S_RS: begin
                    r_cs <= r_q[IN_W-1:0];
                    r_ret <= S_RE; r_state <= S_DIV;
                end
                S_RE: begin
                    r_rs <= r_q[IN_W-1:0];
                    r_ret <= S_MEM; r_state <= S_DIV;
                end
                S_MEM: begin
                    r_re <= r_q[IN_W-1:0];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sr <= acc_r; r_sg <= acc_g; r_sb <= acc_b;
                    r_emit <= n_icp == r_ce && n_irp == r_re;
                    r_state <= (n_icp == r_ce && n_irp == r_re) ? S_CNT : S_UPD;
                end
                S_CNT: begin
                    r_count <= (prod[CNT_W-1:0] == '0) ? CNT_W'(1) : prod[CNT_W-1:0];
                    r_state <= S_MR;
                end
                S_MR: begin
                    r_ret <= S_MG; r_state <= S_DIV;
                end
                S_MG: begin
                    r_ar <= r_q[7:0];
                    r_ret <= S_MB; r_state <= S_DIV;
                end
                S_MB: begin
                    r_ag <= r_q[7:0];
                    r_ret <= S_OUT; r_state <= S_DIV;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid    <= 1'b1;
                        o_avg_red   <= r_ar;
                        o_avg_green <= r_ag;
                        o_avg_blue  <= r_q[7:0];
                        o_out_col   <= r_ocp;
                        o_out_line  <= r_orp;
                        o_frame_done <= OSZ_W'(r_ocp) + OSZ_W'(1) == r_w
                                     && OSZ_W'(r_orp) + OSZ_W'(1) == r_h;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (n_icp >= cw) begin
                        r_icp <= '0;
                        if (n_irp >= ch) begin
                            r_irp <= '0; r_ocp <= '0; r_orp <= '0;
                        end else begin
                            r_irp <= n_irp[POS_W-1:0];
                            if (n_irp >= r_re && OSZ_W'(r_orp) + OSZ_W'(1) < r_h)
                                r_orp <= r_orp + OPOS_W'(1);
                        end
                    end else begin
                        r_icp <= n_icp[POS_W-1:0];
                    end
                    r_state <= S_IDLE;
                end
                S_DIV: begin
                    if (r_dcnt == DCNT_W'(1)) r_state <= r_ret;
                    r_dcnt <= r_dcnt - DCNT_W'(1);
                end
                default: r_state <= S_IDLE;
            endcase

            // Division launch from each state that hands an operand pair to S_DIV.
            if (r_state == S_SZW || r_state == S_SZH || r_state == S_CS
                || r_state == S_RS || r_state == S_RE
                || (r_state == S_CE0 && {1'b0, r_orp} < r_h)
                || (r_state == S_CE1 && {1'b0, r_icp} >= r_q[IN_W-1:0]
                    && OSZ_W'(r_ocp) + OSZ_W'(1) < r_w)) begin
                r_dcnt <= DCNT_W'(NUM_W);
            end else if (r_state == S_MR || r_state == S_MG || r_state == S_MB) begin
                r_dcnt <= DCNT_W'(NUM_W);
            end
        end
    end

    // Divider datapath and pixel latch.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_pr <= i_pix_red; r_pg <= i_pix_green; r_pb <= i_pix_blue;
        end
        case (r_state)
            S_SZW, S_SZH, S_CE0, S_CE1, S_CS, S_RS, S_RE: begin
                r_q   <= NUM_W'(prod);
                r_den <= den_sel;
                r_rem <= '0;
            end
            S_MR: begin
                r_q   <= {1'b0, r_sr, 1'b0} + NUM_W'(r_count);
                r_den <= {r_count, 1'b0};
                r_rem <= '0;
            end
            S_MG: begin
                r_q   <= {1'b0, r_sg, 1'b0} + NUM_W'(r_count);
                r_den <= {r_count, 1'b0};
                r_rem <= '0;
            end
            S_MB: begin
                r_q   <= {1'b0, r_sb, 1'b0} + NUM_W'(r_count);
                r_den <= {r_count, 1'b0};
                r_rem <= '0;
            end
            S_DIV: begin
                r_rem <= take ? trial - {1'b0, r_den} : trial;
                r_q   <= {r_q[NUM_W-2:0], take};
            end
            default: ;
        endcase
    end

    // Column sum RAM.
    always_ff @(posedge i_clk) begin
        if (r_state == S_MEM) r_rdata <= r_mem[r_ocp];
        if (r_state == S_ACC) r_mem[r_ocp] <= {acc_r, acc_g, acc_b};
    end

    always_comb begin
        case (paddr[3:2])
            REG_IN_WIDTH:    prdata = {{(32-IN_W){1'b0}}, r_in_width};
            REG_IN_HEIGHT:   prdata = {{(32-IN_W){1'b0}}, r_in_height};
            REG_OUT_EDGE:    prdata = {{(32-EDGE_W){1'b0}}, r_edge_len};
            default:         prdata = '0;
        endcase
    end

    assign pready  = 1'b1;
    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_ovalid;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted pixel did not start work");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_dcnt != '0)
        else $error("divider running with empty step count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && r_ovalid && i_stall |=> r_state == S_OUT && r_ovalid)
        else $error("output word loaded over a pending word");

    a_emit_only_on_box_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CNT |-> r_emit)
        else $error("mean computed for a pixel that closes no box");

endmodule
`default_nettype wire
